@@ rtl/eihp_pkg.sv @@
// ----------------------------------------------------------------------------
// Header parser package
// Shared types and constants of the Ethernet, IPv4 and layer-4 header parser.
// ----------------------------------------------------------------------------
package eihp_pkg;

  localparam int unsigned LengthBitsDefault = 16;
  localparam int unsigned QueueDepth        = 2;

  localparam logic [7:0]  EthHdrLen     = 8'd14;
  localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
  localparam logic [7:0]  ProtoTcp      = 8'd6;
  localparam logic [7:0]  ProtoUdp      = 8'd17;
  localparam logic [3:0]  IpVersion4    = 4'd4;
  localparam logic [3:0]  MinWords      = 4'd5;
  localparam logic [16:0] CountClip     = 17'h1FFFF;

  typedef enum logic [2:0] {
    ResInvalid = 3'd0,
    ResNonIp   = 3'd1,
    ResTcp     = 3'd2,
    ResUdp     = 3'd3,
    ResOther   = 3'd4
  } result_code_e;

  typedef struct packed {
    logic [16:0] frame_cnt;
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic [15:0] ether_type;
    logic [7:0]  ver_ihl;
    logic [15:0] ip_total_len;
    logic [7:0]  ttl;
    logic [7:0]  proto;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] l4_word1;
    logic [31:0] l4_word2;
    logic [31:0] l4_word3;
  } snap_t;

  typedef struct packed {
    logic        pad;
    logic [39:0] ack_and_flags;
    logic [31:0] seq_or_udp_len;
    logic [15:0] dest_port;
    logic [15:0] source_port;
    logic [31:0] dest_ip;
    logic [31:0] source_ip;
    logic [35:0] ip_fields;
    logic [15:0] ether_type;
    logic [47:0] source_mac;
    logic [47:0] dest_mac;
    logic [15:0] frame_length;
    logic [2:0]  result_code;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);

endpackage

@@ rtl/eihp_front.sv @@
// ----------------------------------------------------------------------------
// Header parser front end
// Counts frame bytes and captures header fields; hands a snapshot of the
// captured headers to the queue on the last byte of each frame.
// ----------------------------------------------------------------------------
module eihp_front #(
  parameter int unsigned LengthBits = eihp_pkg::LengthBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                byte_valid_i,
  output logic                byte_ready_o,
  input  logic [7:0]          data_byte_i,
  input  logic                last_byte_i,
  output logic                snap_valid_o,
  input  logic                snap_ready_i,
  output eihp_pkg::snap_t     snap_o
);

  localparam int unsigned CntW = (LengthBits > 17) ? LengthBits : 17;

  logic [LengthBits-1:0] cnt_q, cnt_d, cnt_inc;
  logic [47:0] dmac_q, dmac_d, smac_q, smac_d;
  logic [15:0] etype_q, etype_d, tlen_q, tlen_d;
  logic [7:0]  ver_ihl_q, ver_ihl_d, ttl_q, ttl_d, proto_q, proto_d;
  logic [31:0] sip_q, sip_d, dip_q, dip_d;
  logic [15:0] sport_q, sport_d, dport_q, dport_d;
  logic [31:0] w1_q, w1_d, w2_q, w2_d, w3_q, w3_d;

  logic           accept;
  logic           pos_small;
  logic [7:0]     pos8, rel_ip, l4off, rel_l4;
  logic           l4_hit;
  logic [CntW-1:0] cnt_ext;

  assign byte_ready_o = snap_ready_i;
  assign accept       = byte_valid_i && snap_ready_i;
  assign snap_valid_o = accept && last_byte_i;

  assign cnt_inc   = (cnt_q != '1) ? cnt_q + 1'b1 : cnt_q;
  assign cnt_ext   = CntW'(cnt_inc);
  assign pos_small = (cnt_q[LengthBits-1:8] == '0);
  assign pos8      = cnt_q[7:0];
  assign rel_ip    = pos8 - eihp_pkg::EthHdrLen;
  assign l4off     = eihp_pkg::EthHdrLen + {2'b00, ver_ihl_q[3:0], 2'b00};
  assign rel_l4    = pos8 - l4off;
  assign l4_hit    = pos_small && (pos8 > eihp_pkg::EthHdrLen) && (pos8 >= l4off) &&
                     (rel_l4 < 8'd16);

  always_comb begin
    cnt_d     = cnt_q;
    dmac_d    = dmac_q;
    smac_d    = smac_q;
    etype_d   = etype_q;
    ver_ihl_d = ver_ihl_q;
    tlen_d    = tlen_q;
    ttl_d     = ttl_q;
    proto_d   = proto_q;
    sip_d     = sip_q;
    dip_d     = dip_q;
    sport_d   = sport_q;
    dport_d   = dport_q;
    w1_d      = w1_q;
    w2_d      = w2_q;
    w3_d      = w3_q;

    if (accept) begin
      cnt_d = cnt_inc;
      if (pos_small) begin
        if (pos8 < 8'd6) begin
          dmac_d = {dmac_q[39:0], data_byte_i};
        end else if (pos8 < 8'd12) begin
          smac_d = {smac_q[39:0], data_byte_i};
        end else if (pos8 < 8'd14) begin
          etype_d = {etype_q[7:0], data_byte_i};
        end else if (pos8 < 8'd34) begin
          case (rel_ip)
            8'd0:    ver_ihl_d = data_byte_i;
            8'd2:    tlen_d = {data_byte_i, tlen_q[7:0]};
            8'd3:    tlen_d = {tlen_q[15:8], data_byte_i};
            8'd8:    ttl_d = data_byte_i;
            8'd9:    proto_d = data_byte_i;
            default: begin
              if (rel_ip >= 8'd12 && rel_ip < 8'd16) begin
                sip_d = {sip_q[23:0], data_byte_i};
              end else if (rel_ip >= 8'd16) begin
                dip_d = {dip_q[23:0], data_byte_i};
              end
            end
          endcase
        end
      end
      if (l4_hit) begin
        case (rel_l4[3:2])
          2'd0: begin
            if (rel_l4[1] == 1'b0) begin
              sport_d = {sport_q[7:0], data_byte_i};
            end else begin
              dport_d = {dport_q[7:0], data_byte_i};
            end
          end
          2'd1:    w1_d = {w1_q[23:0], data_byte_i};
          2'd2:    w2_d = {w2_q[23:0], data_byte_i};
          default: w3_d = {w3_q[23:0], data_byte_i};
        endcase
      end
    end

    snap_o.frame_cnt    = (cnt_ext > CntW'(eihp_pkg::CountClip)) ? eihp_pkg::CountClip
                                                                  : cnt_ext[16:0];
    snap_o.dest_mac     = dmac_d;
    snap_o.source_mac   = smac_d;
    snap_o.ether_type   = etype_d;
    snap_o.ver_ihl      = ver_ihl_d;
    snap_o.ip_total_len = tlen_d;
    snap_o.ttl          = ttl_d;
    snap_o.proto        = proto_d;
    snap_o.source_ip    = sip_d;
    snap_o.dest_ip      = dip_d;
    snap_o.source_port  = sport_d;
    snap_o.dest_port    = dport_d;
    snap_o.l4_word1     = w1_d;
    snap_o.l4_word2     = w2_d;
    snap_o.l4_word3     = w3_d;

    if (accept && last_byte_i) begin
      cnt_d     = '0;
      dmac_d    = '0;
      smac_d    = '0;
      etype_d   = '0;
      ver_ihl_d = '0;
      tlen_d    = '0;
      ttl_d     = '0;
      proto_d   = '0;
      sip_d     = '0;
      dip_d     = '0;
      sport_d   = '0;
      dport_d   = '0;
      w1_d      = '0;
      w2_d      = '0;
      w3_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      dmac_q    <= '0;
      smac_q    <= '0;
      etype_q   <= '0;
      ver_ihl_q <= '0;
      tlen_q    <= '0;
      ttl_q     <= '0;
      proto_q   <= '0;
      sip_q     <= '0;
      dip_q     <= '0;
      sport_q   <= '0;
      dport_q   <= '0;
      w1_q      <= '0;
      w2_q      <= '0;
      w3_q      <= '0;
    end else begin
      cnt_q     <= cnt_d;
      dmac_q    <= dmac_d;
      smac_q    <= smac_d;
      etype_q   <= etype_d;
      ver_ihl_q <= ver_ihl_d;
      tlen_q    <= tlen_d;
      ttl_q     <= ttl_d;
      proto_q   <= proto_d;
      sip_q     <= sip_d;
      dip_q     <= dip_d;
      sport_q   <= sport_d;
      dport_q   <= dport_d;
      w1_q      <= w1_d;
      w2_q      <= w2_d;
      w3_q      <= w3_d;
    end
  end

endmodule

@@ rtl/eihp_queue.sv @@
// ----------------------------------------------------------------------------
// Header parser snapshot queue
// Short first-in first-out queue of header snapshots between the front end
// and the checking back end.
// ----------------------------------------------------------------------------
module eihp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  eihp_pkg::snap_t in_snap_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output eihp_pkg::snap_t out_snap_o
);

  localparam int unsigned Depth = eihp_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  eihp_pkg::snap_t entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign in_ready_o  = (count_q != CntW'(Depth));
  assign out_valid_o = (count_q != '0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_ready_i && out_valid_o;
  assign out_snap_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= in_snap_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("Queue fill count exceeds its depth.");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("Queue fill count did not rise on a lone push.");

  a_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> (count_q == $past(count_q) - 1'b1))
    else $error("Queue fill count did not fall on a lone pop.");

endmodule

@@ rtl/eihp_back.sv @@
// ----------------------------------------------------------------------------
// Header parser back end
// Runs the length and format checks on a header snapshot and holds the
// result in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module eihp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              snap_valid_i,
  output logic              snap_ready_o,
  input  eihp_pkg::snap_t   snap_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output eihp_pkg::result_t res_o
);

  eihp_pkg::result_t res_q, res_d;
  logic              res_valid_q;
  logic              load;

  logic [3:0]  ihl, doff;
  logic [5:0]  hdr;
  logic [16:0] n;
  logic [15:0] pay, ulen;
  logic        ip_bad, tcp_bad, udp_bad, bad;

  assign snap_ready_o = !res_valid_q || res_ready_i;
  assign load         = snap_valid_i && snap_ready_o;
  assign res_valid_o  = res_valid_q;
  assign res_o        = res_q;

  assign n    = snap_i.frame_cnt;
  assign ihl  = snap_i.ver_ihl[3:0];
  assign hdr  = {ihl, 2'b00};
  assign pay  = snap_i.ip_total_len - 16'(hdr);
  assign doff = snap_i.l4_word3[31:28];
  assign ulen = snap_i.l4_word1[31:16];

  assign ip_bad = (n < 17'd34) || (snap_i.ver_ihl[7:4] != eihp_pkg::IpVersion4) ||
                  (ihl < eihp_pkg::MinWords) ||
                  (17'(hdr) + 17'(eihp_pkg::EthHdrLen) > n) ||
                  (17'(snap_i.ip_total_len) + 17'(eihp_pkg::EthHdrLen) > n) ||
                  (snap_i.ip_total_len < 16'(hdr));
  assign tcp_bad = (pay < 16'd20) || (doff < eihp_pkg::MinWords) ||
                   (16'({doff, 2'b00}) > pay);
  assign udp_bad = (pay < 16'd8) || (ulen < 16'd8) || (ulen > pay);

  always_comb begin
    res_d = '0;
    bad   = 1'b0;
    if (n < 17'(eihp_pkg::EthHdrLen)) begin
      bad = 1'b1;
    end else begin
      res_d.frame_length = n[16] ? 16'hFFFF : n[15:0];
      res_d.dest_mac     = snap_i.dest_mac;
      res_d.source_mac   = snap_i.source_mac;
      res_d.ether_type   = snap_i.ether_type;
      if (snap_i.ether_type != eihp_pkg::EtherTypeIpv4) begin
        res_d.result_code = eihp_pkg::ResNonIp;
      end else if (ip_bad) begin
        bad = 1'b1;
      end else begin
        res_d.ip_fields = {ihl, snap_i.ttl, snap_i.proto, snap_i.ip_total_len};
        res_d.source_ip = snap_i.source_ip;
        res_d.dest_ip   = snap_i.dest_ip;
        if (snap_i.proto == eihp_pkg::ProtoTcp) begin
          bad                  = tcp_bad;
          res_d.result_code    = eihp_pkg::ResTcp;
          res_d.source_port    = snap_i.source_port;
          res_d.dest_port      = snap_i.dest_port;
          res_d.seq_or_udp_len = snap_i.l4_word1;
          res_d.ack_and_flags  = {snap_i.l4_word2, snap_i.l4_word3[23:16]};
        end else if (snap_i.proto == eihp_pkg::ProtoUdp) begin
          bad                  = udp_bad;
          res_d.result_code    = eihp_pkg::ResUdp;
          res_d.source_port    = snap_i.source_port;
          res_d.dest_port      = snap_i.dest_port;
          res_d.seq_or_udp_len = 32'(ulen);
        end else begin
          res_d.result_code = eihp_pkg::ResOther;
        end
      end
    end
    if (bad) begin
      res_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (snap_ready_o) begin
      res_valid_q <= snap_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && (res_q.result_code == eihp_pkg::ResInvalid)) |->
    (res_q[eihp_pkg::ResultW-1:3] == '0))
    else $error("An invalid result carries non-zero fields.");

endmodule

@@ rtl/eth_ipv4_l4_header_parser.sv @@
// ----------------------------------------------------------------------------
// Ethernet, IPv4 and TCP/UDP header parser
// Takes a frame one byte per item and returns one header summary per frame.
// ----------------------------------------------------------------------------
// The slave channel carries one frame byte per item in wire order, with tlast
// on the final byte of the frame. The master channel carries one result item
// per frame: the result code, the saturated frame length, the Ethernet fields
// and, for IPv4 frames that pass every check, the IP and TCP or UDP fields.
// A frame that fails a check gives a result of all zeros.
// Bytes are taken at one per cycle while tready is high. A frame's result is
// registered in the snapshot queue and then in the output register once its
// last byte is accepted; a new frame may start in the cycle after that byte.
// Between the byte front end and the checking back end sits a two-entry queue
// of header snapshots, and the result sits in an output register. While the
// receiver stalls, bytes keep flowing until the queue holds two finished
// frames; tready then falls until the receiver takes a result.
// Reset clears the byte counter, the capture registers, the queue and the
// output valid flag; the block is ready for bytes in the first cycle after.
// ----------------------------------------------------------------------------
module eth_ipv4_l4_header_parser #(
  parameter int unsigned LENGTH_BITS = eihp_pkg::LengthBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [7:0]                   s_axis_tdata_i,  // data_byte
  input  logic                         s_axis_tlast_i,  // last_byte
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // result_code, frame_length, dest_mac, source_mac, ether_type, ip_fields,
  // source_ip, dest_ip, source_port, dest_port, seq_or_udp_len,
  // ack_and_flags, one zero pad bit
  output logic [eihp_pkg::ResultW-1:0] m_axis_tdata_o
);

  eihp_pkg::snap_t   front_snap, queue_snap;
  eihp_pkg::result_t result;
  logic              front_valid, front_ready, queue_valid, queue_ready;

  eihp_front #(
    .LengthBits (LENGTH_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid_i),
    .byte_ready_o (s_axis_tready_o),
    .data_byte_i  (s_axis_tdata_i),
    .last_byte_i  (s_axis_tlast_i),
    .snap_valid_o (front_valid),
    .snap_ready_i (front_ready),
    .snap_o       (front_snap)
  );

  eihp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .in_snap_i   (front_snap),
    .out_valid_o (queue_valid),
    .out_ready_i (queue_ready),
    .out_snap_o  (queue_snap)
  );

  eihp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (queue_valid),
    .snap_ready_o (queue_ready),
    .snap_i       (queue_snap),
    .res_valid_o  (m_axis_tvalid_o),
    .res_ready_i  (m_axis_tready_i),
    .res_o        (result)
  );

  assign m_axis_tdata_o = result;

endmodule

@@ verif/tb_eth_ipv4_l4_header_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Header parser testbench
// Feeds Ethernet frames byte by byte, directed corner cases first and then
// mostly well-formed IPv4 TCP, UDP and other frames with random content,
// mixed with broken frames and noise. A predictor tracks the captured header
// state per byte and the checks on the last byte; every result item is
// compared field by field with the oldest prediction. Both sides stall at
// random, the receiver twice holds off long enough to fill the block, and
// the sender now and then waits for all outstanding results.
// ----------------------------------------------------------------------------
module tb_eth_ipv4_l4_header_parser;

  localparam int unsigned IdleLimit     = 5000;
  localparam int unsigned LongHold      = 1200;
  localparam logic [7:0]  ProtoIcmp     = 8'd1;
  localparam logic [15:0] EtherTypeIpv6 = 16'h86DD;

  typedef struct {
    logic [7:0] data;
    logic       last;
    int         gap;
    bit         wait_drain;
  } byte_item_t;

  logic                         clk_i      = 1'b0;
  logic                         rst_ni     = 1'b0;
  logic                         byte_valid = 1'b0;
  logic                         byte_ready;
  logic [7:0]                   byte_data  = '0;
  logic                         byte_last  = 1'b0;
  logic                         sum_valid;
  logic                         sum_ready  = 1'b0;
  logic [eihp_pkg::ResultW-1:0] sum_data;

  byte_item_t        byte_q[$];
  eihp_pkg::result_t summary_q[$];
  logic [7:0]        frm[$];

  logic [15:0] hdr_count;
  logic [47:0] dst_mac_cap, src_mac_cap;
  logic [15:0] etype_cap, tot_len_cap, sport_cap, dport_cap;
  logic [7:0]  ver_ihl_cap, ttl_cap, proto_cap;
  logic [31:0] src_ip_cap, dst_ip_cap;
  logic [31:0] l4_words[4];

  byte_item_t        next_item;
  bit                frame_done;
  eihp_pkg::result_t frame_sum, want_sum, got_sum;
  int                send_wait, rx_wait, idle_cycles;
  int                bytes_sent, results_seen, fault_count, queued_bytes, random_frames;
  int                code_tally[5];

  eth_ipv4_l4_header_parser dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (byte_valid),
    .s_axis_tready_o (byte_ready),
    .s_axis_tdata_i  (byte_data),
    .s_axis_tlast_i  (byte_last),
    .m_axis_tvalid_o (sum_valid),
    .m_axis_tready_i (sum_ready),
    .m_axis_tdata_o  (sum_data)
  );

  always #5 clk_i = ~clk_i;

  task automatic clear_capture();
    hdr_count   = '0;
    dst_mac_cap = '0;
    src_mac_cap = '0;
    etype_cap   = '0;
    tot_len_cap = '0;
    sport_cap   = '0;
    dport_cap   = '0;
    ver_ihl_cap = '0;
    ttl_cap     = '0;
    proto_cap   = '0;
    src_ip_cap  = '0;
    dst_ip_cap  = '0;
    for (int i = 0; i < 4; i++) l4_words[i] = '0;
  endtask

  function automatic eihp_pkg::result_t frame_verdict();
    eihp_pkg::result_t r;
    int n, avail, ihl, hlen, pay, doff, ulen;
    r = '0;
    n = int'(hdr_count);
    if (n < int'(eihp_pkg::EthHdrLen)) return '0;
    r.frame_length = hdr_count;
    r.dest_mac     = dst_mac_cap;
    r.source_mac   = src_mac_cap;
    r.ether_type   = etype_cap;
    if (etype_cap != eihp_pkg::EtherTypeIpv4) begin
      r.result_code = eihp_pkg::ResNonIp;
      return r;
    end
    avail = n - int'(eihp_pkg::EthHdrLen);
    ihl   = int'(ver_ihl_cap[3:0]);
    hlen  = ihl * 4;
    if (avail < 20 || ver_ihl_cap[7:4] != eihp_pkg::IpVersion4 ||
        ihl < int'(eihp_pkg::MinWords) || hlen > avail)
      return '0;
    if (int'(tot_len_cap) > avail || int'(tot_len_cap) < hlen) return '0;
    pay = int'(tot_len_cap) - hlen;
    r.ip_fields = {ver_ihl_cap[3:0], ttl_cap, proto_cap, tot_len_cap};
    r.source_ip = src_ip_cap;
    r.dest_ip   = dst_ip_cap;
    if (proto_cap == eihp_pkg::ProtoTcp) begin
      doff = int'(l4_words[3][31:28]);
      if (pay < 20 || doff < int'(eihp_pkg::MinWords) || doff * 4 > pay) return '0;
      r.result_code    = eihp_pkg::ResTcp;
      r.source_port    = sport_cap;
      r.dest_port      = dport_cap;
      r.seq_or_udp_len = l4_words[1];
      r.ack_and_flags  = {l4_words[2], l4_words[3][23:16]};
    end else if (proto_cap == eihp_pkg::ProtoUdp) begin
      ulen = int'(l4_words[1][31:16]);
      if (pay < 8 || ulen < 8 || ulen > pay) return '0;
      r.result_code    = eihp_pkg::ResUdp;
      r.source_port    = sport_cap;
      r.dest_port      = dport_cap;
      r.seq_or_udp_len = {16'h0, l4_words[1][31:16]};
    end else begin
      r.result_code = eihp_pkg::ResOther;
    end
    return r;
  endfunction

  task automatic absorb_byte(input logic [7:0] b, input logic eof, output bit done,
                             output eihp_pkg::result_t verdict);
    int pos, rel, l4_off;
    pos = int'(hdr_count);
    if (pos < 6) begin
      dst_mac_cap = {dst_mac_cap[39:0], b};
    end else if (pos < 12) begin
      src_mac_cap = {src_mac_cap[39:0], b};
    end else if (pos < 14) begin
      etype_cap = {etype_cap[7:0], b};
    end else if (pos < 34) begin
      rel = pos - 14;
      case (rel)
        0: ver_ihl_cap = b;
        2: tot_len_cap[15:8] = b;
        3: tot_len_cap[7:0] = b;
        8: ttl_cap = b;
        9: proto_cap = b;
        default: begin
          if (rel >= 12 && rel < 16) src_ip_cap = {src_ip_cap[23:0], b};
          else if (rel >= 16) dst_ip_cap = {dst_ip_cap[23:0], b};
        end
      endcase
    end
    if (pos > 14 && pos < 256) begin
      l4_off = 14 + int'(ver_ihl_cap[3:0]) * 4;
      if (pos >= l4_off && pos - l4_off < 16) begin
        rel = pos - l4_off;
        l4_words[rel / 4] = {l4_words[rel / 4][23:0], b};
        if (rel < 2) sport_cap = {sport_cap[7:0], b};
        else if (rel < 4) dport_cap = {dport_cap[7:0], b};
      end
    end
    if (hdr_count != 16'hFFFF) hdr_count++;
    done    = eof;
    verdict = '0;
    if (eof) begin
      verdict = frame_verdict();
      clear_capture();
    end
  endtask

  task automatic put_be(input logic [63:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) frm.push_back(v[8*i +: 8]);
  endtask

  task automatic put_rand(input int n);
    for (int i = 0; i < n; i++) frm.push_back(8'($urandom));
  endtask

  task automatic start_frame(input logic [15:0] etype);
    frm.delete();
    put_be({$urandom, $urandom}, 6);
    put_be({$urandom, $urandom}, 6);
    put_be(64'(etype), 2);
  endtask

  task automatic noise_frame(input int len, input logic [7:0] fill, input bit use_fill);
    frm.delete();
    for (int i = 0; i < len; i++) frm.push_back(use_fill ? fill : 8'($urandom));
  endtask

  // For TCP len_field is the data offset, for UDP the length field.
  task automatic build_ipv4(input logic [7:0] proto, input int ihl_w, input int body_len,
                            input int tl_adj, input int len_field, input int trailer);
    int base, tl;
    logic [3:0]  ihl_n, doff_n;
    logic [15:0] ulen_v;
    ihl_n  = 4'(ihl_w);
    doff_n = 4'(len_field);
    ulen_v = 16'(len_field);
    tl     = ihl_w * 4 + body_len + tl_adj;
    start_frame(eihp_pkg::EtherTypeIpv4);
    frm.push_back({eihp_pkg::IpVersion4, ihl_n});
    put_rand(1);
    put_be(64'(tl), 2);
    put_rand(4);
    put_rand(1);
    frm.push_back(proto);
    put_rand(2);
    put_be({$urandom, $urandom}, 8);
    put_rand(ihl_w * 4 - 20);
    base = frm.size();
    put_rand(body_len);
    if (proto == eihp_pkg::ProtoTcp && body_len > 12) begin
      frm[base+12] = {doff_n, frm[base+12][3:0]};
    end
    if (proto == eihp_pkg::ProtoUdp && body_len > 5) begin
      frm[base+4] = ulen_v[15:8];
      frm[base+5] = ulen_v[7:0];
    end
    put_rand(trailer);
  endtask

  // Sets the MAC, TTL, IP and layer-4 bytes of a minimal TCP frame to one value.
  task automatic flood_fields(input logic [7:0] v);
    build_ipv4(eihp_pkg::ProtoTcp, 5, 20, 0, 5, 0);
    for (int i = 0; i < 12; i++) frm[i] = v;
    frm[22] = v;
    for (int i = 26; i < 54; i++) frm[i] = v;
    frm[46] = {4'd5, v[3:0]};
  endtask

  task automatic random_frame();
    int kind, ihl_w, doff, body, ulen, idx;
    logic [7:0]  p;
    logic [15:0] et;
    kind  = $urandom_range(0, 99);
    ihl_w = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 15) : 5;
    if (kind < 35) begin
      doff = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
      body = doff * 4 + $urandom_range(0, 16);
      build_ipv4(eihp_pkg::ProtoTcp, ihl_w, body, 0, doff, $urandom_range(0, 10));
    end else if (kind < 65) begin
      body = 8 + $urandom_range(0, 30);
      ulen = ($urandom_range(0, 2) == 0) ? $urandom_range(8, body) : body;
      build_ipv4(eihp_pkg::ProtoUdp, ihl_w, body, 0, ulen, $urandom_range(0, 10));
    end else if (kind < 75) begin
      do p = 8'($urandom); while (p == eihp_pkg::ProtoTcp || p == eihp_pkg::ProtoUdp);
      build_ipv4(p, ihl_w, $urandom_range(0, 20), 0, 0, $urandom_range(0, 10));
    end else if (kind < 85) begin
      do et = 16'($urandom); while (et == eihp_pkg::EtherTypeIpv4);
      start_frame(et);
      put_rand($urandom_range(0, 50));
    end else if (kind < 92) begin
      start_frame(eihp_pkg::EtherTypeIpv4);
      put_rand($urandom_range(6, 60));
    end else begin
      noise_frame($urandom_range(1, 70), 8'h00, 1'b0);
    end
    if (kind < 85 && $urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 2))
        0: begin
          idx = $urandom_range(1, frm.size());
          while (frm.size() > idx) void'(frm.pop_back());
        end
        1: frm[$urandom_range(12, frm.size() - 1)] = 8'($urandom);
        default: begin
          if (frm.size() > 14) begin
            idx = $urandom_range(14, (frm.size() > 61) ? 60 : frm.size() - 1);
            frm[idx] = frm[idx] ^ (8'h01 << $urandom_range(0, 7));
          end
        end
      endcase
    end
  endtask

  task automatic send_frame(input bit drain_first, input bit quiet);
    byte_item_t it;
    foreach (frm[i]) begin
      it.data       = frm[i];
      it.last       = (i == frm.size() - 1);
      it.gap        = quiet ? 0 : $urandom_range(0, 6);
      it.wait_drain = drain_first && (i == 0);
      byte_q.push_back(it);
    end
    queued_bytes += frm.size();
  endtask

  task automatic compare_field(input string fname, input logic [63:0] want_v,
                               input logic [63:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, fname, want_v, got_v);
      fault_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_valid <= 1'b0;
      byte_data  <= '0;
      byte_last  <= 1'b0;
      send_wait = 0;
    end else begin
      if (byte_valid && byte_ready) begin
        absorb_byte(byte_data, byte_last, frame_done, frame_sum);
        if (frame_done) begin
          summary_q.push_back(frame_sum);
          code_tally[int'(frame_sum.result_code)]++;
        end
        bytes_sent++;
      end
      if (!(byte_valid && !byte_ready)) begin
        if (send_wait > 0) begin
          send_wait--;
          byte_valid <= 1'b0;
        end else if (byte_q.size() != 0 &&
                     !(byte_q[0].wait_drain && summary_q.size() != 0)) begin
          next_item = byte_q.pop_front();
          byte_data  <= next_item.data;
          byte_last  <= next_item.last;
          byte_valid <= 1'b1;
          send_wait = next_item.gap;
        end else begin
          byte_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (sum_valid && sum_ready) begin
        got_sum = eihp_pkg::result_t'(sum_data);
        if (summary_q.size() == 0) begin
          $display("%0t: result item with no frame outstanding, expected none, got 0x%0h",
                   $time, sum_data);
          fault_count++;
        end else begin
          want_sum = summary_q.pop_front();
          compare_field("result_code", 64'(want_sum.result_code),
                        64'(got_sum.result_code));
          compare_field("frame_length", 64'(want_sum.frame_length),
                        64'(got_sum.frame_length));
          compare_field("dest_mac", 64'(want_sum.dest_mac), 64'(got_sum.dest_mac));
          compare_field("source_mac", 64'(want_sum.source_mac), 64'(got_sum.source_mac));
          compare_field("ether_type", 64'(want_sum.ether_type), 64'(got_sum.ether_type));
          compare_field("ip_fields", 64'(want_sum.ip_fields), 64'(got_sum.ip_fields));
          compare_field("source_ip", 64'(want_sum.source_ip), 64'(got_sum.source_ip));
          compare_field("dest_ip", 64'(want_sum.dest_ip), 64'(got_sum.dest_ip));
          compare_field("source_port", 64'(want_sum.source_port),
                        64'(got_sum.source_port));
          compare_field("dest_port", 64'(want_sum.dest_port), 64'(got_sum.dest_port));
          compare_field("seq_or_udp_len", 64'(want_sum.seq_or_udp_len),
                        64'(got_sum.seq_or_udp_len));
          compare_field("ack_and_flags", 64'(want_sum.ack_and_flags),
                        64'(got_sum.ack_and_flags));
        end
        results_seen++;
        rx_wait = ((results_seen / 12) % 3 == 1) ? 0 : $urandom_range(0, 6);
        if (results_seen == 8 || results_seen == 20) rx_wait = LongHold;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        sum_ready <= 1'b0;
      end else begin
        sum_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (byte_valid && byte_ready) || (sum_valid && sum_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no item moved for %0d cycles", $time, IdleLimit);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    clear_capture();
    noise_frame(1, 8'h00, 1'b0);
    send_frame(1'b0, 1'b0);
    noise_frame(13, 8'h00, 1'b0);
    send_frame(1'b0, 1'b0);
    start_frame(EtherTypeIpv6);
    send_frame(1'b0, 1'b0);
    start_frame(eihp_pkg::EtherTypeIpv4);
    send_frame(1'b0, 1'b0);
    build_ipv4(ProtoIcmp, 5, 0, 0, 0, 0);
    void'(frm.pop_back());
    send_frame(1'b0, 1'b0);
    build_ipv4(eihp_pkg::ProtoTcp, 5, 20, 0, 5, 0);
    send_frame(1'b0, 1'b1);
    build_ipv4(eihp_pkg::ProtoUdp, 5, 8, 0, 8, 0);
    send_frame(1'b1, 1'b1);
    build_ipv4(ProtoIcmp, 5, 0, 0, 0, 0);
    send_frame(1'b0, 1'b0);
    build_ipv4(eihp_pkg::ProtoTcp, 5, 20, 0, 5, 0);
    frm[14] = 8'h65;
    send_frame(1'b0, 1'b0);
    build_ipv4(eihp_pkg::ProtoUdp, 4, 12, 0, 8, 0);
    send_frame(1'b0, 1'b0);
    build_ipv4(eihp_pkg::ProtoTcp, 15, 24, 0, 6, 0);
    send_frame(1'b0, 1'b0);
    build_ipv4(eihp_pkg::ProtoUdp, 5, 8, 1, 8, 0);
    send_frame(1'b0, 1'b0);
    build_ipv4(ProtoIcmp, 6, 0, -1, 0, 4);
    send_frame(1'b0, 1'b0);
    build_ipv4(eihp_pkg::ProtoTcp, 5, 24, 0, 4, 0);
    send_frame(1'b0, 1'b0);
    build_ipv4(eihp_pkg::ProtoTcp, 5, 24, 0, 7, 0);
    send_frame(1'b0, 1'b0);
    build_ipv4(eihp_pkg::ProtoTcp, 5, 16, 0, 5, 4);
    send_frame(1'b0, 1'b0);
    build_ipv4(eihp_pkg::ProtoUdp, 5, 12, 0, 7, 0);
    send_frame(1'b0, 1'b0);
    build_ipv4(eihp_pkg::ProtoUdp, 5, 10, 0, 11, 0);
    send_frame(1'b0, 1'b0);
    build_ipv4(eihp_pkg::ProtoUdp, 5, 6, 0, 8, 4);
    send_frame(1'b0, 1'b0);
    noise_frame(20, 8'hFF, 1'b1);
    send_frame(1'b0, 1'b0);
    noise_frame(20, 8'h00, 1'b1);
    send_frame(1'b0, 1'b0);
    flood_fields(8'hFF);
    send_frame(1'b0, 1'b0);
    flood_fields(8'h00);
    send_frame(1'b0, 1'b0);

    while (queued_bytes < 850 || random_frames < 3) begin
      random_frame();
      send_frame(random_frames % 15 == 14, (random_frames / 8) % 3 == 0);
      random_frames++;
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (byte_q.size() != 0 || byte_valid || summary_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Parsed %0d frames from %0d bytes: %0d TCP, %0d UDP, %0d other IP, %0d non-IPv4,",
             results_seen, bytes_sent, code_tally[eihp_pkg::ResTcp],
             code_tally[eihp_pkg::ResUdp], code_tally[eihp_pkg::ResOther],
             code_tally[eihp_pkg::ResNonIp]);
    $display("%0d rejected; included short and malformed frames, long output stalls and pauses.",
             code_tally[eihp_pkg::ResInvalid]);
    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
